FILE: src/assert_macros.svh
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is high
`define SBQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SBQ_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/sbq_pkg.sv
`default_nettype none
package sbq_pkg;

   localparam int SAMPLE_WIDTH    = 24;
   localparam int COEF_WIDTH      = 32;
   localparam int COEF_FRAC_BITS  = 28;
   localparam int PROD_WIDTH      = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH       = PROD_WIDTH + 3;
   localparam int SHIFT_WIDTH     = ACC_WIDTH - COEF_FRAC_BITS;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = COEF_WIDTH;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [COEF_WIDTH-1:0]   coef_word_type;
   typedef logic signed [PROD_WIDTH-1:0]   prod_type;
   typedef logic signed [ACC_WIDTH-1:0]    acc_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ENABLE  = 3'd0,
      CSR_COEF_B0 = 3'd1,
      CSR_COEF_B1 = 3'd2,
      CSR_COEF_B2 = 3'd3,
      CSR_COEF_A1 = 3'd4,
      CSR_COEF_A2 = 3'd5
   } csr_index_type;

   typedef struct packed {
      coef_word_type b0;
      coef_word_type b1;
      coef_word_type b2;
      coef_word_type a1;
      coef_word_type a2;
   } coef_set_type;

   typedef struct packed {
      logic load_s1;
      logic load_s2;
      logic load_s3;
      logic s2_full;
   } pipe_ctrl_type;

   localparam coef_word_type COEF_ONE   = coef_word_type'(longint'(1) << COEF_FRAC_BITS);
   localparam acc_type       ROUND_BIAS = acc_type'(longint'(1) << (COEF_FRAC_BITS - 1));
   localparam sample_type    SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam sample_type    SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   function automatic prod_type mul_sc(sample_type s, coef_word_type c);
      prod_type se;
      prod_type ce;
      se = {{COEF_WIDTH{s[SAMPLE_WIDTH-1]}}, s};
      ce = {{SAMPLE_WIDTH{c[COEF_WIDTH-1]}}, c};
      return se * ce;
   endfunction

   function automatic acc_type ext_prod(prod_type p);
      return {{(ACC_WIDTH-PROD_WIDTH){p[PROD_WIDTH-1]}}, p};
   endfunction

endpackage
`default_nettype wire

FILE: src/sbq_req_if.sv
`default_nettype none
interface sbq_req_if;
   logic                valid;
   logic                ready;
   sbq_pkg::sample_type left_in;
   sbq_pkg::sample_type right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink (input valid, input left_in, input right_in, output ready);
endinterface
`default_nettype wire

FILE: src/sbq_rsp_if.sv
`default_nettype none
interface sbq_rsp_if;
   logic                valid;
   logic                ready;
   sbq_pkg::sample_type left_out;
   sbq_pkg::sample_type right_out;
   logic                clipped;

   modport source (output valid, output left_out, output right_out, output clipped,
                   input ready);
   modport sink (input valid, input left_out, input right_out, input clipped,
                 output ready);
endinterface
`default_nettype wire

FILE: src/sbq_ctrl.sv
`default_nettype none
module sbq_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output sbq_pkg::pipe_ctrl_type      ctrl
);

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic load_s1, load_s2, load_s3;

   always_comb begin
      load_s3 = s2_valid_ff && (!out_valid_ff || rsp_ready);
      load_s2 = s1_valid_ff && (!s2_valid_ff || load_s3);
      load_s1 = req_valid && (!s1_valid_ff || load_s2);

      s1_valid_in  = load_s1 || (s1_valid_ff && !load_s2);
      s2_valid_in  = load_s2 || (s2_valid_ff && !load_s3);
      out_valid_in = load_s3 || (out_valid_ff && !rsp_ready);
   end

   always_comb begin
      req_ready    = !s1_valid_ff || load_s2;
      rsp_valid    = out_valid_ff;
      ctrl.load_s1 = load_s1;
      ctrl.load_s2 = load_s2;
      ctrl.load_s3 = load_s3;
      ctrl.s2_full = s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/sbq_lane.sv
`default_nettype none
module sbq_lane (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   enable,
   input  wire sbq_pkg::coef_set_type  coef,
   input  wire sbq_pkg::pipe_ctrl_type ctrl,
   input  wire sbq_pkg::sample_type    sample_in,
   output sbq_pkg::sample_type         y_out,
   output logic                        clip_out
);

   // sample history, cleared at reset
   sbq_pkg::sample_type x1_ff, x2_ff, y1_ff, y2_ff;

   // pipeline payload
   sbq_pkg::prod_type p0_ff, p1_ff, p2_ff;
   sbq_pkg::prod_type p0_in, p1_in, p2_in;
   sbq_pkg::acc_type  s2_ff, s2_in;

   sbq_pkg::sample_type                            y2_sel;
   sbq_pkg::acc_type                               acc;
   logic signed [sbq_pkg::SHIFT_WIDTH-1:0]         shifted;
   logic [sbq_pkg::SHIFT_WIDTH-sbq_pkg::SAMPLE_WIDTH:0] top_bits;
   logic                                           in_range;

   // feedforward products
   always_comb begin
      p0_in = sbq_pkg::mul_sc(sample_in, coef.b0);
      p1_in = sbq_pkg::mul_sc(x1_ff, coef.b1);
      p2_in = sbq_pkg::mul_sc(x2_ff, coef.b2);
   end

   // second-back output: in y1 while the item ahead is still in stage 2, else in y2
   always_comb begin
      y2_sel = ctrl.s2_full ? y1_ff : y2_ff;
      s2_in  = sbq_pkg::ext_prod(p0_ff) + sbq_pkg::ext_prod(p1_ff)
             + sbq_pkg::ext_prod(p2_ff) - sbq_pkg::ext_prod(sbq_pkg::mul_sc(y2_sel, coef.a2))
             + sbq_pkg::ROUND_BIAS;
   end

   // recursive tap, rounding shift and saturation
   always_comb begin
      acc      = s2_ff - sbq_pkg::ext_prod(sbq_pkg::mul_sc(y1_ff, coef.a1));
      shifted  = acc[sbq_pkg::ACC_WIDTH-1:sbq_pkg::COEF_FRAC_BITS];
      top_bits = shifted[sbq_pkg::SHIFT_WIDTH-1:sbq_pkg::SAMPLE_WIDTH-1];
      in_range = (top_bits == '0) || (top_bits == '1);
      if (in_range) begin
         y_out = shifted[sbq_pkg::SAMPLE_WIDTH-1:0];
      end else if (shifted[sbq_pkg::SHIFT_WIDTH-1]) begin
         y_out = sbq_pkg::SAMPLE_MIN;
      end else begin
         y_out = sbq_pkg::SAMPLE_MAX;
      end
      clip_out = !in_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else begin
         if (ctrl.load_s1 && enable) begin
            x2_ff <= x1_ff;
            x1_ff <= sample_in;
         end
         if (ctrl.load_s3 && enable) begin
            y2_ff <= y1_ff;
            y1_ff <= y_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_s1) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
      if (ctrl.load_s2) begin
         s2_ff <= s2_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/sbq_merge.sv
`default_nettype none
module sbq_merge (
   input  wire logic                   clock,
   input  wire sbq_pkg::pipe_ctrl_type ctrl,
   input  wire logic                   enable,
   input  wire sbq_pkg::sample_type    y_left,
   input  wire sbq_pkg::sample_type    y_right,
   input  wire logic                   clip_left,
   input  wire logic                   clip_right,
   output sbq_pkg::sample_type         left_out,
   output sbq_pkg::sample_type         right_out,
   output logic                        clipped
);

   sbq_pkg::sample_type left_ff, left_in, right_ff, right_in;
   logic                clipped_ff, clipped_in;

   // silence while disabled
   always_comb begin
      left_in    = enable ? y_left : '0;
      right_in   = enable ? y_right : '0;
      clipped_in = enable && (clip_left || clip_right);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_s3) begin
         left_ff    <= left_in;
         right_ff   <= right_in;
         clipped_ff <= clipped_in;
      end
   end

   assign left_out  = left_ff;
   assign right_out = right_ff;
   assign clipped   = clipped_ff;

endmodule
`default_nettype wire

FILE: src/stereo_biquad_filter.sv
// Stereo second-order IIR filter (direct form I), one left/right pair per item.
// req_chan carries left_in/right_in, rsp_chan carries left_out/right_out/clipped;
// both use valid/ready and move an item at a clock edge with both high.
// csr_we/csr_index/csr_wdata write enable (index 0) and the Q4.28 taps b0, b1, b2,
// a1, a2 (indices 1 to 5); other indices are ignored. Write only while no item
// is in flight.
// An accepted item passes the product register, the partial sum register and
// the output register before it is shown on rsp_chan.
// Throughput: one item per cycle while the receiver keeps up. The limiting
// path is the a1 feedback loop: one multiply by the last output, the
// accumulate, rounding and saturation back into the output history, per lane.
// Reset clears the sample histories and the pipeline, sets enable to 0 and the
// taps to unity pass-through. While disabled, items give zero and leave the
// histories alone.
// When the receiver stalls, the output register holds its item and the input
// keeps accepting until the three stages are full.
`default_nettype none
module stereo_biquad_filter (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   sbq_req_if.sink                                   req_chan,
   sbq_rsp_if.source                                 rsp_chan,
   input  wire logic                                 csr_we,
   input  wire logic [sbq_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [sbq_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   logic                   enable_ff, enable_in;
   sbq_pkg::coef_set_type  coef_ff, coef_in;
   sbq_pkg::pipe_ctrl_type ctrl;
   sbq_pkg::sample_type    y_left, y_right;
   logic                   clip_left, clip_right;

   always_comb begin
      enable_in = enable_ff;
      coef_in   = coef_ff;
      if (csr_we) begin
         unique case (csr_index)
            sbq_pkg::CSR_ENABLE:  enable_in  = csr_wdata[0];
            sbq_pkg::CSR_COEF_B0: coef_in.b0 = csr_wdata;
            sbq_pkg::CSR_COEF_B1: coef_in.b1 = csr_wdata;
            sbq_pkg::CSR_COEF_B2: coef_in.b2 = csr_wdata;
            sbq_pkg::CSR_COEF_A1: coef_in.a1 = csr_wdata;
            sbq_pkg::CSR_COEF_A2: coef_in.a2 = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         coef_ff.b0 <= sbq_pkg::COEF_ONE;
         coef_ff.b1 <= '0;
         coef_ff.b2 <= '0;
         coef_ff.a1 <= '0;
         coef_ff.a2 <= '0;
      end else begin
         enable_ff <= enable_in;
         coef_ff   <= coef_in;
      end
   end

   sbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .ctrl      (ctrl)
   );

   sbq_lane u_lane_left (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable_ff),
      .coef      (coef_ff),
      .ctrl      (ctrl),
      .sample_in (req_chan.left_in),
      .y_out     (y_left),
      .clip_out  (clip_left)
   );

   sbq_lane u_lane_right (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable_ff),
      .coef      (coef_ff),
      .ctrl      (ctrl),
      .sample_in (req_chan.right_in),
      .y_out     (y_right),
      .clip_out  (clip_right)
   );

   sbq_merge u_merge (
      .clock      (clock),
      .ctrl       (ctrl),
      .enable     (enable_ff),
      .y_left     (y_left),
      .y_right    (y_right),
      .clip_left  (clip_left),
      .clip_right (clip_right),
      .left_out   (rsp_chan.left_out),
      .right_out  (rsp_chan.right_out),
      .clipped    (rsp_chan.clipped)
   );

endmodule
`default_nettype wire

FILE: src/sbq_checker.sv
`default_nettype none
`include "assert_macros.svh"
module sbq_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire sbq_pkg::sample_type left_out,
   input wire sbq_pkg::sample_type right_out,
   input wire logic                clipped
);

   // a stalled result holds
   `SBQ_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready |=> rsp_valid && $stable(left_out) && $stable(right_out) && $stable(clipped)), "stalled item changed")

   // a clipped item shows a full-scale sample on some channel
   `SBQ_ASSERT(a_clip_full_scale, clock, reset, (rsp_valid && clipped |-> left_out == sbq_pkg::SAMPLE_MAX || left_out == sbq_pkg::SAMPLE_MIN || right_out == sbq_pkg::SAMPLE_MAX || right_out == sbq_pkg::SAMPLE_MIN), "clipped without saturation")

   // reset empties the output
   `SBQ_ASSERT_NR(a_reset_empty, clock, (reset |=> !rsp_valid), "item after reset")

   // latency bound when the receiver keeps up
   `SBQ_ASSERT(a_latency, clock, reset, ((req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready |=> rsp_valid), "item late")

   // an empty output never blocks the input
   `SBQ_ASSERT(a_ready_when_empty, clock, reset, (!rsp_valid |-> req_ready), "input blocked while output empty")

endmodule

bind stereo_biquad_filter sbq_checker u_sbq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .left_out  (rsp_chan.left_out),
   .right_out (rsp_chan.right_out),
   .clipped   (rsp_chan.clipped)
);
`default_nettype wire

FILE: bench/stereo_biquad_filter_tb.sv
`timescale 1ns / 100ps
module stereo_biquad_filter_tb;
   import sbq_pkg::*;

   localparam int     QUIET_LIMIT = 2000;
   localparam int     LONG_HOLD   = 60;
   localparam int     PHASE_ITEMS = 60;
   localparam longint LANE_MAX    = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
   localparam longint LANE_MIN    = -LANE_MAX - 1;
   localparam longint ROUND_HALF  = longint'(1) <<< (COEF_FRAC_BITS - 1);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 3'd7;

   // typical low-pass section, Q4.28
   localparam logic [31:0] LP_B0 = 32'sd18119393;
   localparam logic [31:0] LP_B1 = 32'sd36238787;
   localparam logic [31:0] LP_B2 = 32'sd18119393;
   localparam logic [31:0] LP_A1 = -32'sd306821726;
   localparam logic [31:0] LP_A2 = 32'sd110810157;

   localparam logic [31:0] TAP_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] TAP_MIN  = 32'h8000_0000;
   localparam logic [31:0] TAP_HALF = 32'h0800_0000;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } stereo_sample_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
      logic       clipped;
   } stereo_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   sbq_req_if req_chan ();
   sbq_rsp_if rsp_chan ();

   stereo_biquad_filter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // filter state as the block should hold it
   logic          run_filter;
   coef_word_type tap_b0, tap_b1, tap_b2, tap_a1, tap_a2;
   sample_type    x_hist [2][2];
   sample_type    y_hist [2][2];

   stereo_sample_type pending_pairs [$];
   stereo_result_type expected_pairs [$];

   int   fault_count     = 0;
   int   send_gap        = 0;
   int   stall_left      = 0;
   int   hold_left       = 0;
   int   quiet_cycles    = 0;
   logic hold_taken      = 1'b0;
   logic hold_req        = 1'b0;
   logic sender_pauses   = 1'b0;
   logic receiver_pauses = 1'b0;

   always #1 clock = ~clock;

   function automatic sample_type filter_lane(input int lane, input sample_type x0,
                                              inout logic clip);
      longint     acc;
      sample_type y0;
      acc = longint'(x0) * longint'(tap_b0)
          + longint'(x_hist[lane][0]) * longint'(tap_b1)
          + longint'(x_hist[lane][1]) * longint'(tap_b2)
          - longint'(y_hist[lane][0]) * longint'(tap_a1)
          - longint'(y_hist[lane][1]) * longint'(tap_a2);
      acc = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
      if (acc > LANE_MAX) begin
         y0   = SAMPLE_MAX;
         clip = 1'b1;
      end else if (acc < LANE_MIN) begin
         y0   = SAMPLE_MIN;
         clip = 1'b1;
      end else begin
         y0 = sample_type'(acc);
      end
      x_hist[lane][1] = x_hist[lane][0];
      x_hist[lane][0] = x0;
      y_hist[lane][1] = y_hist[lane][0];
      y_hist[lane][0] = y0;
      return y0;
   endfunction

   function automatic stereo_result_type filter_stereo(input sample_type l,
                                                       input sample_type r);
      stereo_result_type res;
      logic              clip;
      clip = 1'b0;
      res  = '0;
      if (run_filter) begin
         res.left    = filter_lane(0, l, clip);
         res.right   = filter_lane(1, r, clip);
         res.clipped = clip;
      end
      return res;
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         3: return sample_type'(int'($urandom_range(0, 16)) - 8);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] extreme_tap();
      case ($urandom_range(0, 2))
         0: return TAP_MAX;
         1: return TAP_MIN;
         default: return '0;
      endcase
   endfunction

   function automatic logic [31:0] moderate_tap();
      return 32'($signed($urandom) >>> 3);
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_ENABLE:  run_filter = data[0];
         CSR_COEF_B0: tap_b0 = data;
         CSR_COEF_B1: tap_b1 = data;
         CSR_COEF_B2: tap_b2 = data;
         CSR_COEF_A1: tap_a1 = data;
         CSR_COEF_A2: tap_a2 = data;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_taps(input logic [31:0] b0, input logic [31:0] b1, input logic [31:0] b2,
                           input logic [31:0] a1, input logic [31:0] a2);
      write_csr(CSR_COEF_B0, b0);
      write_csr(CSR_COEF_B1, b1);
      write_csr(CSR_COEF_B2, b2);
      write_csr(CSR_COEF_A1, a1);
      write_csr(CSR_COEF_A2, a2);
   endtask

   task automatic push_pair(input sample_type l, input sample_type r);
      pending_pairs.push_back('{left: l, right: r});
   endtask

   task automatic wait_drained();
      while (pending_pairs.size() != 0 || req_chan.valid || expected_pairs.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // sender
   always @(posedge clock) begin : driver
      stereo_sample_type next_pair;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_pairs.push_back(filter_stereo(req_chan.left_in, req_chan.right_in));
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap == 0 && sender_pauses && $urandom_range(0, 4) == 0)
               send_gap = $urandom_range(1, 4);
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_pairs.size() != 0) begin
               next_pair = pending_pairs.pop_front();
               req_chan.valid    <= 1'b1;
               req_chan.left_in  <= next_pair.left;
               req_chan.right_in <= next_pair.right;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin : monitor
      stereo_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_pairs.size() == 0) begin
               fault_count++;
               $display("%0t: item with nothing expected, left %0d right %0d clipped %0b",
                        $time, rsp_chan.left_out, rsp_chan.right_out, rsp_chan.clipped);
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_chan.left_out !== want.left) begin
                  fault_count++;
                  $display("%0t: left_out expected %0d actual %0d",
                           $time, want.left, rsp_chan.left_out);
               end
               if (rsp_chan.right_out !== want.right) begin
                  fault_count++;
                  $display("%0t: right_out expected %0d actual %0d",
                           $time, want.right, rsp_chan.right_out);
               end
               if (rsp_chan.clipped !== want.clipped) begin
                  fault_count++;
                  $display("%0t: clipped expected %0b actual %0b",
                           $time, want.clipped, rsp_chan.clipped);
               end
            end
         end
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (receiver_pauses && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_chan.valid    = 1'b0;
      req_chan.left_in  = '0;
      req_chan.right_in = '0;
      rsp_chan.ready    = 1'b0;
      run_filter        = 1'b0;
      tap_b0            = COEF_ONE;
      tap_b1            = '0;
      tap_b2            = '0;
      tap_a1            = '0;
      tap_a2            = '0;
      for (int lane = 0; lane < 2; lane++) begin
         for (int d = 0; d < 2; d++) begin
            x_hist[lane][d] = '0;
            y_hist[lane][d] = '0;
         end
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // disabled after reset: silence
      sender_pauses   = 1'b1;
      receiver_pauses = 1'b1;
      push_pair(SAMPLE_MAX, SAMPLE_MIN);
      push_pair(SAMPLE_MIN, SAMPLE_MAX);
      push_pair('0, -24'sd1);
      push_pair(24'h555555, 24'hAAAAAA);
      wait_drained();

      // upper bits of enable ignored, spare indexes ignored
      write_csr(CSR_ENABLE, 32'hFFFF_FFFE);
      write_csr(CSR_ENABLE, 32'h0000_0001);
      write_csr(CSR_SPARE_LO, $urandom);
      write_csr(CSR_SPARE_HI, $urandom);

      // unity pass-through
      push_pair(SAMPLE_MAX, SAMPLE_MIN);
      push_pair(SAMPLE_MIN, SAMPLE_MAX);
      push_pair('0, '0);
      push_pair(-24'sd1, 24'sd1);
      push_pair(24'h555555, 24'hAAAAAA);
      wait_drained();

      // half gain: rounding ties go up
      write_csr(CSR_COEF_B0, TAP_HALF);
      push_pair(24'sd1, -24'sd1);
      push_pair(24'sd3, -24'sd3);
      push_pair(-24'sd1, 24'sd1);
      wait_drained();

      // saturation both ways
      write_csr(CSR_COEF_B0, TAP_MAX);
      push_pair(SAMPLE_MAX, 24'sd1);
      push_pair(24'sd1, SAMPLE_MIN);
      wait_drained();
      write_csr(CSR_COEF_B0, TAP_MIN);
      push_pair(SAMPLE_MIN, SAMPLE_MAX);
      push_pair(SAMPLE_MAX, '0);
      wait_drained();
      set_taps(TAP_MAX, TAP_MAX, TAP_MAX, TAP_MAX, TAP_MAX);
      push_pair(SAMPLE_MAX, SAMPLE_MIN);
      push_pair(SAMPLE_MIN, SAMPLE_MAX);
      wait_drained();

      // long receiver hold with the sender still offering
      set_taps(LP_B0, LP_B1, LP_B2, LP_A1, LP_A2);
      sender_pauses = 1'b0;
      hold_req      = 1'b1;
      for (int i = 0; i < 40; i++)
         push_pair(pick_sample(), pick_sample());
      wait_drained();

      for (int phase = 0; phase < 12; phase++) begin
         sender_pauses   = (phase < 10) && ($urandom_range(0, 3) != 0);
         receiver_pauses = (phase < 10) && ($urandom_range(0, 3) != 0);
         if (phase % 5 == 4) begin
            write_csr(CSR_ENABLE, $urandom & ~32'h1);
         end else begin
            write_csr(CSR_ENABLE, $urandom | 32'h1);
            case (phase % 5)
               0: set_taps(LP_B0, LP_B1, LP_B2, LP_A1, LP_A2);
               1: set_taps(moderate_tap(), moderate_tap(), moderate_tap(),
                           moderate_tap(), moderate_tap());
               2: set_taps($urandom, $urandom, $urandom, $urandom, $urandom);
               default: set_taps(extreme_tap(), extreme_tap(), extreme_tap(),
                                 extreme_tap(), extreme_tap());
            endcase
         end
         if ($urandom_range(0, 2) == 0)
            write_csr($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, $urandom);
         for (int i = 0; i < PHASE_ITEMS; i++)
            push_pair(pick_sample(), pick_sample());
         wait_drained();
      end

      repeat (10) @(negedge clock);
      if (fault_count == 0 && expected_pairs.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: files.f
+incdir+src
src/sbq_pkg.sv
src/sbq_req_if.sv
src/sbq_rsp_if.sv
src/sbq_ctrl.sv
src/sbq_lane.sv
src/sbq_merge.sv
src/stereo_biquad_filter.sv
src/sbq_checker.sv
bench/stereo_biquad_filter_tb.sv
